// ----- rtl/kbf_pkg.sv -----
// Shared types and constants for the key event to character FIFO.
package kbf_pkg;

    // Configuration register indexes and widths.
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_PRESSED_STATE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASED_STATE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_KEY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_SHIFT_KEY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SHIFT_KEY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BREAK_KEY      = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [7:0] RST_PRESSED_STATE   = 8'd1;
    localparam logic [7:0] RST_RELEASED_STATE  = 8'd3;
    localparam logic [7:0] RST_CONTROL_KEY     = 8'd165;
    localparam logic [7:0] RST_LEFT_SHIFT_KEY  = 8'd162;
    localparam logic [7:0] RST_RIGHT_SHIFT_KEY = 8'd163;
    localparam logic [7:0] RST_BREAK_KEY       = 8'd208;

    // Character translation constants.
    localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CTRL_MASK     = 8'h1F;
    localparam logic [7:0] CASE_BIT      = 8'h20;
    localparam logic [7:0] CHAR_LF       = 8'h0A;
    localparam logic [7:0] CHAR_CR       = 8'h0D;
    localparam logic [7:0] STATE_NONE    = 8'h00;

    // Input function codes.
    localparam logic FUNC_EVENT = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // Operations handed from the front to the back.
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_BREAK = 2'd1;
    localparam logic [1:0] OP_PUSH  = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] ch;
    } t_cmd;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] char_out;
        logic       break_seen;
        logic       chars_waiting;
        logic       dropped;
    } t_res;

endpackage

// ----- rtl/kbf_in_if.sv -----
// Input channel carrying key events and read requests.
interface kbf_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] event_state;
    logic [7:0] event_key;

    modport source (output valid, output func, output event_state, output event_key,
                    input ready);
    modport sink (input valid, input func, input event_state, input event_key,
                  output ready);
endinterface

// ----- rtl/kbf_out_if.sv -----
// Output channel carrying one result beat per input beat.
interface kbf_out_if;
    logic       valid;
    logic       ready;
    logic       char_valid;
    logic [7:0] char_out;
    logic       break_seen;
    logic       chars_waiting;
    logic       dropped;

    modport source (output valid, output char_valid, output char_out, output break_seen,
                    output chars_waiting, output dropped, input ready);
    modport sink (input valid, input char_valid, input char_out, input break_seen,
                  input chars_waiting, input dropped, output ready);
endinterface

// ----- rtl/kbf_front.sv -----
// Front end: configuration registers, modifier tracking and event classification.
module kbf_front
    import kbf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    input  logic                  i_func,
    input  logic [7:0]            i_state,
    input  logic [7:0]            i_key,
    output logic                  o_ready,
    output logic                  o_cmd_valid,
    input  logic                  i_cmd_ready,
    output t_cmd                  o_cmd
);

    logic [7:0] r_pressed, r_released, r_ctrl_key, r_lshift_key, r_rshift_key, r_break_key;
    logic       r_ctrl_held, r_shift_held;
    logic       n_ctrl_held, n_shift_held;
    logic       accept;
    logic       is_shift;
    logic       is_lower;
    logic [7:0] ch_mod;
    logic [7:0] ch_final;
    t_cmd       cmd;

    // Every beat becomes one command, so the front stalls only on the queue.
    assign o_ready     = i_cmd_ready;
    assign o_cmd_valid = i_valid;
    assign accept      = i_valid && i_cmd_ready;
    assign o_cmd       = cmd;

    // Configuration writes; indexes past the last register are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed    <= RST_PRESSED_STATE;
            r_released   <= RST_RELEASED_STATE;
            r_ctrl_key   <= RST_CONTROL_KEY;
            r_lshift_key <= RST_LEFT_SHIFT_KEY;
            r_rshift_key <= RST_RIGHT_SHIFT_KEY;
            r_break_key  <= RST_BREAK_KEY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PRESSED_STATE:   r_pressed    <= i_cfg_data;
                REG_RELEASED_STATE:  r_released   <= i_cfg_data;
                REG_CONTROL_KEY:     r_ctrl_key   <= i_cfg_data;
                REG_LEFT_SHIFT_KEY:  r_lshift_key <= i_cfg_data;
                REG_RIGHT_SHIFT_KEY: r_rshift_key <= i_cfg_data;
                REG_BREAK_KEY:       r_break_key  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Translate the key code with the modifiers currently held.
    always_comb begin
        is_lower = (i_key >= CHAR_LOWER_A) && (i_key <= CHAR_LOWER_Z);
        ch_mod   = i_key;
        if (is_lower && r_ctrl_held) begin
            ch_mod = ch_mod & CTRL_MASK;
        end
        if (is_lower && r_shift_held) begin
            ch_mod = ch_mod & ~CASE_BIT;
        end
        ch_final = (ch_mod == CHAR_LF) ? CHAR_CR : ch_mod;
    end

    // Classify the beat; control wins over shift, shift over break.
    always_comb begin
        is_shift     = (i_key == r_lshift_key) || (i_key == r_rshift_key);
        n_ctrl_held  = r_ctrl_held;
        n_shift_held = r_shift_held;
        cmd.op       = OP_NONE;
        cmd.ch       = ch_final;
        if (i_func == FUNC_READ) begin
            cmd.op = OP_READ;
        end else if (i_state != STATE_NONE) begin
            if (i_state == r_pressed) begin
                if (i_key == r_ctrl_key) begin
                    n_ctrl_held = 1'b1;
                end else if (is_shift) begin
                    n_shift_held = 1'b1;
                end else if (i_key == r_break_key) begin
                    cmd.op = OP_BREAK;
                end
            end else if (i_state == r_released) begin
                if (i_key == r_ctrl_key) begin
                    n_ctrl_held = 1'b0;
                end else if (is_shift) begin
                    n_shift_held = 1'b0;
                end else begin
                    cmd.op = OP_PUSH;
                end
            end
        end
    end

    // Modifier flags move only on an accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_held  <= 1'b0;
            r_shift_held <= 1'b0;
        end else if (accept) begin
            r_ctrl_held  <= n_ctrl_held;
            r_shift_held <= n_shift_held;
        end
    end

endmodule

// ----- rtl/kbf_cmd_q.sv -----
// Two-entry command queue between the front end and the buffer back end.
module kbf_cmd_q
    import kbf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cmd i_cmd,
    output logic o_valid,
    input  logic i_ready,
    output t_cmd o_cmd
);

    localparam int unsigned QDEPTH = 2;

    t_cmd       r_slot [QDEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'(QDEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_slot[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // Pointer and occupancy bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

endmodule

// ----- rtl/kbf_back.sv -----
// Back end: character buffer, its pointers and the result output register.
module kbf_back
    import kbf_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    output logic o_cmd_ready,
    input  t_cmd i_cmd,
    output logic o_res_valid,
    input  logic i_res_ready,
    output t_res o_res
);

    localparam int unsigned AW = $clog2(BUFFER_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(BUFFER_DEPTH - 1);

    logic [7:0]    mem [BUFFER_DEPTH];
    logic [AW-1:0] r_wr, r_rd, n_wr, n_rd, wr_adv, rd_adv;
    logic [7:0]    r_rd_data;
    logic          r_out_valid;
    logic          r_char_valid, r_break, r_waiting, r_dropped;
    logic          n_char_valid, n_break, n_dropped;
    logic          take, do_write, do_read;

    assign wr_adv      = (r_wr == LAST) ? '0 : r_wr + 1'b1;
    assign rd_adv      = (r_rd == LAST) ? '0 : r_rd + 1'b1;
    assign take        = i_cmd_valid && (!r_out_valid || i_res_ready);
    assign o_cmd_ready = !r_out_valid || i_res_ready;

    // Carry out one command against the buffer.
    always_comb begin
        n_wr         = r_wr;
        n_rd         = r_rd;
        n_char_valid = 1'b0;
        n_break      = 1'b0;
        n_dropped    = 1'b0;
        do_write     = 1'b0;
        do_read      = 1'b0;
        unique case (i_cmd.op)
            OP_READ: begin
                if (r_rd != r_wr) begin
                    do_read      = 1'b1;
                    n_char_valid = 1'b1;
                    n_rd         = rd_adv;
                end
            end
            OP_BREAK: begin
                n_break = 1'b1;
            end
            OP_PUSH: begin
                if (wr_adv == r_rd) begin
                    n_dropped = 1'b1;
                end else begin
                    do_write = 1'b1;
                    n_wr     = wr_adv;
                end
            end
            default: ;
        endcase
    end

    // Pointers and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr        <= '0;
            r_rd        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_wr        <= n_wr;
                r_rd        <= n_rd;
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, held while the output is stalled.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_char_valid <= n_char_valid;
            r_break      <= n_break;
            r_dropped    <= n_dropped;
            r_waiting    <= (n_rd != n_wr);
        end
    end

    // Character memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (take && do_write) begin
            mem[r_wr] <= i_cmd.ch;
        end
        if (take && do_read) begin
            r_rd_data <= mem[r_rd];
        end
    end

    assign o_res_valid         = r_out_valid;
    assign o_res.char_valid    = r_char_valid;
    assign o_res.char_out      = r_char_valid ? r_rd_data : 8'h00;
    assign o_res.break_seen    = r_break;
    assign o_res.chars_waiting = r_waiting;
    assign o_res.dropped       = r_dropped;

endmodule

// ----- rtl/key_event_to_char_fifo.sv -----
// Top level of the key event to character FIFO.
// Accepts one beat per clock (a key event or a read request) while the command queue has room
// and returns exactly one result beat for each, in order, through the queue and the output
// register. The front end tracks the control and shift modifiers and turns key releases into
// characters; a two-entry command queue decouples it from the back end, which owns a
// BUFFER_DEPTH-entry character memory (one write or one registered read per accepted command)
// and the output register. The buffer holds at most BUFFER_DEPTH-1 characters; a character
// produced while it is full is discarded and flagged as dropped. The memory needs no clearing
// after reset, since only entries already written are ever read. Configuration writes take
// effect at the next edge and are meant to be issued while the block is idle.
module key_event_to_char_fifo
    import kbf_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    kbf_in_if.sink                i_evt,
    kbf_out_if.source             o_res
);

    logic fe_valid, fe_ready;
    t_cmd fe_cmd;
    logic be_valid, be_ready;
    t_cmd be_cmd;
    t_res res;
    logic res_valid;

    // Event classification and modifier tracking.
    kbf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_evt.valid),
        .i_func      (i_evt.func),
        .i_state     (i_evt.event_state),
        .i_key       (i_evt.event_key),
        .o_ready     (i_evt.ready),
        .o_cmd_valid (fe_valid),
        .i_cmd_ready (fe_ready),
        .o_cmd       (fe_cmd)
    );

    // Command queue between the two halves.
    kbf_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fe_valid),
        .o_ready (fe_ready),
        .i_cmd   (fe_cmd),
        .o_valid (be_valid),
        .i_ready (be_ready),
        .o_cmd   (be_cmd)
    );

    // Character buffer and result register.
    kbf_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (be_valid),
        .o_cmd_ready (be_ready),
        .i_cmd       (be_cmd),
        .o_res_valid (res_valid),
        .i_res_ready (o_res.ready),
        .o_res       (res)
    );

    assign o_res.valid         = res_valid;
    assign o_res.char_valid    = res.char_valid;
    assign o_res.char_out      = res.char_out;
    assign o_res.break_seen    = res.break_seen;
    assign o_res.chars_waiting = res.chars_waiting;
    assign o_res.dropped       = res.dropped;

endmodule

// ----- rtl/kbf_checker.sv -----
// Port-level checks for the key event to character FIFO, bound to the top level.
module kbf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic       i_char_valid,
    input logic [7:0] i_char_out,
    input logic       i_break_seen,
    input logic       i_chars_waiting,
    input logic       i_dropped
);

    // A stalled result beat stays offered.
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> i_valid)
        else $error("result valid dropped while stalled");

    // A stalled result beat keeps its character, break and drop fields.
    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> ($stable(i_char_out) && $stable(i_char_valid)
                                   && $stable(i_dropped) && $stable(i_break_seen)))
        else $error("result payload changed while stalled");

    // No character means a zero character byte.
    a_zero_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_char_valid) |-> (i_char_out == 8'h00))
        else $error("character byte nonzero without a valid character");

    // A result is at most one of a read, a break or a drop.
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ($countones({i_char_valid, i_break_seen, i_dropped}) <= 1))
        else $error("result reports more than one outcome");

    // A drop happens only on a full buffer, which is never empty.
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_dropped) |-> i_chars_waiting)
        else $error("drop reported with an empty buffer");

endmodule

bind key_event_to_char_fifo kbf_checker u_kbf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_res.valid),
    .i_ready         (o_res.ready),
    .i_char_valid    (o_res.char_valid),
    .i_char_out      (o_res.char_out),
    .i_break_seen    (o_res.break_seen),
    .i_chars_waiting (o_res.chars_waiting),
    .i_dropped       (o_res.dropped)
);
